/* hw/rtl/khr_pkg.sv */
package khr_pkg;

  localparam int unsigned KEY_W    = 64;
  localparam int unsigned HIT_W    = 16;
  localparam int unsigned MET_W    = 16;
  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned STR_W    = 8;
  localparam int unsigned STAT_W   = 3;
  localparam int unsigned SLOT_W   = 6;
  localparam int unsigned ECNT_W   = 7;

  localparam logic OP_UPSERT = 1'b0;
  localparam logic OP_LIST   = 1'b1;

  localparam logic [STAT_W-1:0] STAT_UPDATED  = 3'd0;
  localparam logic [STAT_W-1:0] STAT_INSERTED = 3'd1;
  localparam logic [STAT_W-1:0] STAT_DROPPED  = 3'd2;
  localparam logic [STAT_W-1:0] STAT_LIST     = 3'd3;
  localparam logic [STAT_W-1:0] STAT_EMPTY    = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_LIST,
    ST_EMIT
  } khr_state_e;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic [SLOT_W-1:0]        slot;
    logic [KEY_W-1:0]         key_out;
    logic [HIT_W-1:0]         hit_count;
    logic signed [MET_W-1:0]  metric_out;
    logic [CHAN_W-1:0]        chan_out;
    logic signed [STR_W-1:0]  strength_out;
    logic [ECNT_W-1:0]        entry_count;
    logic                     last;
  } khr_res_t;

endpackage

/* hw/rtl/khr_if.sv */
interface khr_in_if import khr_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    opcode;
  logic [KEY_W-1:0]        record_key;
  logic [CHAN_W-1:0]       chan_in;
  logic signed [STR_W-1:0] strength_in;
  logic signed [MET_W-1:0] metric_in;

  modport source (output valid, opcode, record_key, chan_in, strength_in, metric_in,
                  input ready);
  modport sink (input valid, opcode, record_key, chan_in, strength_in, metric_in,
                output ready);
endinterface

interface khr_out_if import khr_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [STAT_W-1:0]       status;
  logic [SLOT_W-1:0]       slot;
  logic [KEY_W-1:0]        key_out;
  logic [HIT_W-1:0]        hit_count;
  logic signed [MET_W-1:0] metric_out;
  logic [CHAN_W-1:0]       chan_out;
  logic signed [STR_W-1:0] strength_out;
  logic [ECNT_W-1:0]       entry_count;
  logic                    last;

  modport source (output valid, status, slot, key_out, hit_count, metric_out, chan_out,
                  strength_out, entry_count, last, input ready);
  modport sink (input valid, status, slot, key_out, hit_count, metric_out, chan_out,
                strength_out, entry_count, last, output ready);
endinterface

interface khr_cfg_if ();
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

/* hw/rtl/khr_ram.sv */
module khr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/keyed_hit_table_with_ranking_core.sv */
// Keyed hit table with ranked readout.
// The input channel carries one request per transfer: an upsert (opcode 0)
// with key, channel, strength and metric, or a list request (opcode 1).
// An upsert scans the used slots of the record memory one slot per cycle.
// A hit rewrites that slot; a miss fills the next free slot or drops the key
// when the table is full. Each upsert gives exactly one result transfer.
// A list request emits one result per entry in descending rank order, ties
// in ascending slot order. Each result costs one full pass over the used
// slots (one memory read per cycle). An empty table gives a single
// "empty" result.
// The configuration channel writes rank_by_metric; it is always ready and
// must only be written while the block is idle.
// Results sit in an output register. When the receiver stalls, the block
// holds one more finished result internally and then waits; nothing is lost.
// A new request is accepted once the previous one has produced all its
// results, even while the last one still waits in the output register.
// Reset empties the table at once (the entry count goes to zero) and clears
// rank_by_metric; the record memory itself is not cleared.
module keyed_hit_table_with_ranking_core
  import khr_pkg::*;
#(
  parameter int unsigned ENTRIES  = 64,
  parameter int unsigned KEY_BITS = 64,
  parameter int unsigned HIT_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  khr_in_if.sink     in_ch_i,
  khr_out_if.source  out_ch_o,
  khr_cfg_if.sink    cfg_ch_i
);

  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam int unsigned REC_W = KEY_BITS + HIT_BITS + MET_W + CHAN_W + STR_W;
  localparam int unsigned RV_W  = ((HIT_BITS > MET_W) ? HIT_BITS : MET_W) + 1;

  // Controller state and configuration.
  khr_state_e state_q, state_d;
  logic       rank_q;
  logic [CNT_W-1:0] count_q;

  // Latched request fields.
  logic [KEY_BITS-1:0]     key_q;
  logic [CHAN_W-1:0]       chan_q;
  logic signed [STR_W-1:0] str_q;
  logic signed [MET_W-1:0] met_q;

  // Scan pipeline: the issue index and the slot whose data returns now.
  logic [CNT_W-1:0] iss_q;
  logic             vld_q;
  logic [IDX_W-1:0] slot_q;

  // Ranking pass bookkeeping.
  logic                   first_q, have_q, more_q;
  logic signed [RV_W-1:0] prev_v_q, best_v_q;
  logic [IDX_W-1:0]       prev_s_q, best_s_q;
  logic [REC_W-1:0]       best_rec_q;
  logic [CNT_W-1:0]       emitted_q;

  khr_res_t res_q, out_q;
  logic     out_vld_q;

  // Memory access.
  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr;
  logic [REC_W-1:0] ram_wdata, ram_rdata;

  khr_ram #(
    .WIDTH (REC_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (iss_q[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  // Record fields as read from memory and as held for the best candidate.
  logic [KEY_BITS-1:0]     rd_key, bs_key;
  logic [HIT_BITS-1:0]     rd_hits, bs_hits;
  logic signed [MET_W-1:0] rd_met, bs_met;
  logic [CHAN_W-1:0]       rd_chan, bs_chan;
  logic signed [STR_W-1:0] rd_str, bs_str;

  assign {rd_key, rd_hits, rd_met, rd_chan, rd_str} = ram_rdata;
  assign {bs_key, bs_hits, bs_met, bs_chan, bs_str} = best_rec_q;

  // Rank value of the entry that returns from memory.
  logic signed [RV_W-1:0] rd_rv;
  assign rd_rv = rank_q ? $signed({{(RV_W-MET_W){rd_met[MET_W-1]}}, rd_met})
                        : $signed({{(RV_W-HIT_BITS){1'b0}}, rd_hits});

  // True when entry (va, sa) comes out before entry (vb, sb).
  function automatic logic ranks_before(logic signed [RV_W-1:0] va, logic [IDX_W-1:0] sa,
                                        logic signed [RV_W-1:0] vb, logic [IDX_W-1:0] sb);
    return (va > vb) || ((va == vb) && (sa < sb));
  endfunction

  logic in_fire, out_free, scan_done, hit, full;
  logic eligible, take, list_last;
  logic [HIT_BITS-1:0]     new_hits;
  logic signed [MET_W-1:0] new_met;

  assign in_fire   = in_ch_i.valid && in_ch_i.ready;
  assign out_free  = !out_vld_q || out_ch_o.ready;
  assign scan_done = !vld_q && (iss_q >= count_q);
  assign hit       = (state_q == ST_SEARCH) && vld_q && (rd_key == key_q);
  assign full      = (count_q == CNT_W'(ENTRIES));
  assign ram_re    = ((state_q == ST_SEARCH) || (state_q == ST_LIST))
                     && (iss_q < count_q) && !hit;

  assign new_hits = (rd_hits == {HIT_BITS{1'b1}}) ? rd_hits : rd_hits + 1'b1;
  assign new_met  = (!rank_q || (met_q > rd_met)) ? met_q : rd_met;

  assign eligible  = first_q || ranks_before(prev_v_q, prev_s_q, rd_rv, slot_q);
  assign take      = (state_q == ST_LIST) && vld_q && eligible
                     && (!have_q || ranks_before(rd_rv, slot_q, best_v_q, best_s_q));
  assign list_last = ((emitted_q + 1'b1) == count_q);

  // A hit rewrites its slot; a miss with room appends at the fill count.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = slot_q;
    ram_wdata = {rd_key, new_hits, new_met, chan_q, str_q};
    if (hit) begin
      ram_we = 1'b1;
    end else if ((state_q == ST_SEARCH) && scan_done && !full) begin
      ram_we    = 1'b1;
      ram_waddr = count_q[IDX_W-1:0];
      ram_wdata = {key_q, HIT_BITS'(1), met_q, chan_q, str_q};
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_ch_i.opcode == OP_UPSERT) begin
            state_d = ST_SEARCH;
          end else if (count_q == '0) begin
            state_d = ST_EMIT;
          end else begin
            state_d = ST_LIST;
          end
        end
      end
      ST_SEARCH: begin
        if (hit || scan_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_LIST: begin
        if (scan_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = more_q ? ST_LIST : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      rank_q    <= 1'b0;
      count_q   <= '0;
      out_vld_q <= 1'b0;
      vld_q     <= 1'b0;
      more_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_ch_i.valid) begin
        rank_q <= cfg_ch_i.data;
      end
      vld_q <= ram_re;
      if (ram_we && !hit) begin
        count_q <= count_q + 1'b1;
      end
      if ((state_q == ST_EMIT) && out_free) begin
        out_vld_q <= 1'b1;
      end else if (out_ch_o.ready) begin
        out_vld_q <= 1'b0;
      end
      if ((state_q == ST_LIST) && scan_done) begin
        more_q <= !list_last;
      end else if (state_q == ST_IDLE) begin
        more_q <= 1'b0;
      end
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk_i) begin
    if (ram_re) begin
      iss_q  <= iss_q + 1'b1;
      slot_q <= iss_q[IDX_W-1:0];
    end
    if (take) begin
      have_q     <= 1'b1;
      best_v_q   <= rd_rv;
      best_s_q   <= slot_q;
      best_rec_q <= ram_rdata;
    end
    if ((state_q == ST_EMIT) && out_free) begin
      out_q <= res_q;
    end
    case (state_q)
      ST_IDLE: begin
        iss_q     <= '0;
        first_q   <= 1'b1;
        have_q    <= 1'b0;
        emitted_q <= '0;
        key_q     <= in_ch_i.record_key[KEY_BITS-1:0];
        chan_q    <= in_ch_i.chan_in;
        str_q     <= in_ch_i.strength_in;
        met_q     <= in_ch_i.metric_in;
        res_q     <= '{status: STAT_EMPTY, slot: '0, key_out: '0, hit_count: '0,
                       metric_out: '0, chan_out: '0, strength_out: '0,
                       entry_count: '0, last: 1'b1};
      end
      ST_SEARCH: begin
        if (hit) begin
          res_q <= '{status: STAT_UPDATED, slot: SLOT_W'(slot_q), key_out: KEY_W'(rd_key),
                     hit_count: HIT_W'(new_hits), metric_out: new_met, chan_out: chan_q,
                     strength_out: str_q, entry_count: ECNT_W'(count_q), last: 1'b1};
        end else if (scan_done && full) begin
          res_q <= '{status: STAT_DROPPED, slot: '0, key_out: KEY_W'(key_q),
                     hit_count: '0, metric_out: '0, chan_out: '0, strength_out: '0,
                     entry_count: ECNT_W'(count_q), last: 1'b1};
        end else if (scan_done) begin
          res_q <= '{status: STAT_INSERTED, slot: SLOT_W'(count_q),
                     key_out: KEY_W'(key_q), hit_count: HIT_W'(1), metric_out: met_q,
                     chan_out: chan_q, strength_out: str_q,
                     entry_count: ECNT_W'(count_q + 1'b1), last: 1'b1};
        end
      end
      ST_LIST: begin
        if (scan_done) begin
          res_q <= '{status: STAT_LIST, slot: SLOT_W'(best_s_q), key_out: KEY_W'(bs_key),
                     hit_count: HIT_W'(bs_hits), metric_out: bs_met, chan_out: bs_chan,
                     strength_out: bs_str, entry_count: ECNT_W'(count_q),
                     last: list_last};
          emitted_q <= emitted_q + 1'b1;
          prev_v_q  <= best_v_q;
          prev_s_q  <= best_s_q;
          first_q   <= 1'b0;
          have_q    <= 1'b0;
          iss_q     <= '0;
        end
      end
      default: begin
      end
    endcase
  end

  assign in_ch_i.ready  = (state_q == ST_IDLE);
  assign cfg_ch_i.ready = 1'b1;

  assign out_ch_o.valid        = out_vld_q;
  assign out_ch_o.status       = out_q.status;
  assign out_ch_o.slot         = out_q.slot;
  assign out_ch_o.key_out      = out_q.key_out;
  assign out_ch_o.hit_count    = out_q.hit_count;
  assign out_ch_o.metric_out   = out_q.metric_out;
  assign out_ch_o.chan_out     = out_q.chan_out;
  assign out_ch_o.strength_out = out_q.strength_out;
  assign out_ch_o.entry_count  = out_q.entry_count;
  assign out_ch_o.last         = out_q.last;

  // The fill count never passes the table size.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(ENTRIES))
    else $error("entry count beyond table size");

  // The fill count only grows, and by one entry at a time.
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> (count_q == $past(count_q) + 1'b1))
    else $error("entry count changed by more than one");

  // The record memory is written only while an upsert searches.
  a_write_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_SEARCH))
    else $error("record memory written outside an upsert");

endmodule
